[rtl/lbbt_pkg.sv]
// shared types and constants for the labeled bounding box table
// no dependencies
package lbbt_pkg;

    localparam int CFG_W       = 13;
    localparam int LABEL_W     = 10;
    localparam int FIRST_W     = 12;
    localparam int END_W       = 13;
    localparam int CMP_W       = 17;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic REG_IDX_HEIGHT = 1'b0;
    localparam logic REG_IDX_WIDTH  = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1024;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1024;

    typedef enum logic [1:0] {
        K_PIXEL       = 2'd0,
        K_PIXEL_SKIP  = 2'd1,
        K_READ        = 2'd2,
        K_READ_ABSENT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_back_state;

endpackage

[rtl/labeled_bounding_box_table.sv]
// top level of the labeled bounding box table: apb registers, front end, queue,
// back end and box ram; depends on lbbt_pkg and all lbbt_ modules
//
// usage: label pixels enter in raster order as command transactions (start while
// busy is low, command 0). a read (command 1) returns one label's box one cycle
// long on o_result_valid; the receiver cannot stall, so results are never held.
// the first pixel of a frame (raster position 0,0) clears all valid marks and
// the overflow flag. image_height at address 0 and image_width at address 4 are
// written over the apb port while the block is idle.
// throughput: the front end accepts one transaction per cycle into a 4-entry
// queue; the back end reads the box ram, then does the update or result, and
// pops the next transaction only once that is done, so busy rises while the
// queue is full.
// a read transaction passes through the queue, the back end's idle state (box
// ram read), exec state and result register, queued behind any ahead of it.
// reset: synchronous, clears raster counters, valid marks, queue and registers
// to 1024 x 1024; the box ram needs no clearing since valid marks guard it.
module labeled_bounding_box_table
    import lbbt_pkg::*;
#(
    parameter int NUM_LABELS = 256,
    parameter int MAX_DIM    = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [LABEL_W-1:0]    i_label,
    output logic                  o_result_valid,
    output logic                  o_present,
    output logic [FIRST_W-1:0]    o_row_first,
    output logic [END_W-1:0]      o_row_end,
    output logic [FIRST_W-1:0]    o_col_first,
    output logic [END_W-1:0]      o_col_end,
    output logic                  o_label_overflow
);

    localparam int LBL_W = $clog2(NUM_LABELS);
    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int ENT_W = 4 + LBL_W + 2 * DIM_W;
    localparam int BOX_W = 4 * DIM_W;

    logic [CFG_W-1:0] r_height, r_width;
    logic             cfg_wr, accept;
    logic             push, pop, q_full, q_empty;
    logic [ENT_W-1:0] push_data, q_data;
    logic             ram_we, ram_re;
    logic [LBL_W-1:0] ram_waddr, ram_raddr;
    logic [BOX_W-1:0] ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_IDX_WIDTH) ? APB_DATA_W'(r_width)
                                                : APB_DATA_W'(r_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RESET;
            r_width  <= WIDTH_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_IDX_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                REG_IDX_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                default:        r_height <= r_height;
            endcase
        end
    end

    assign busy   = q_full;
    assign accept = start && !busy;

    lbbt_front #(
        .NUM_LABELS (NUM_LABELS),
        .MAX_DIM    (MAX_DIM),
        .LBL_W      (LBL_W),
        .DIM_W      (DIM_W),
        .ENT_W      (ENT_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_command),
        .i_label   (i_label),
        .i_height  (r_height),
        .i_width   (r_width),
        .o_push    (push),
        .o_entry   (push_data)
    );

    lbbt_queue #(
        .ENT_W (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lbbt_back #(
        .NUM_LABELS (NUM_LABELS),
        .LBL_W      (LBL_W),
        .DIM_W      (DIM_W),
        .ENT_W      (ENT_W),
        .BOX_W      (BOX_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_data),
        .o_q_pop          (pop),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .o_result_valid   (o_result_valid),
        .o_present        (o_present),
        .o_row_first      (o_row_first),
        .o_row_end        (o_row_end),
        .o_col_first      (o_col_first),
        .o_col_end        (o_col_end),
        .o_label_overflow (o_label_overflow)
    );

    lbbt_ram #(
        .WIDTH (BOX_W),
        .DEPTH (NUM_LABELS)
    ) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    a_no_back_to_back_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe in two consecutive cycles");

    a_absent_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_present) |->
            (o_row_first == '0) && (o_row_end == '0) &&
            (o_col_first == '0) && (o_col_end == '0))
        else $error("absent label returned a nonzero box");

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty at once");

    a_result_needs_transaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !$past(q_empty, 2))
        else $error("result strobe without a queued transaction");

    a_present_has_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_present) |->
            (o_row_end != '0) || (o_col_end != '0) || (MAX_DIM > 4096))
        else $error("present box with empty extent");
`endif

endmodule

[rtl/lbbt_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module lbbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lbbt_front.sv]
// front end: raster counters, frame start and label range classification
// depends on lbbt_pkg
module lbbt_front
    import lbbt_pkg::*;
#(
    parameter int NUM_LABELS = 256,
    parameter int MAX_DIM    = 4096,
    parameter int LBL_W      = 8,
    parameter int DIM_W      = 12,
    parameter int ENT_W      = 4 + LBL_W + 2 * DIM_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_command,
    input  logic [LABEL_W-1:0] i_label,
    input  logic [CFG_W-1:0]   i_height,
    input  logic [CFG_W-1:0]   i_width,
    output logic               o_push,
    output logic [ENT_W-1:0]   o_entry
);

    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    logic             r_ovf, n_ovf;

    logic [CMP_W-1:0] h_raw, w_raw, h_sz, w_sz;
    logic [CMP_W-1:0] row_inc, col_inc;
    logic             frame_start;
    logic             in_range;
    t_kind            kind;
    logic             ent_ovf;

    always_comb begin
        h_raw = CMP_W'(i_height);
        w_raw = CMP_W'(i_width);
        if (h_raw == '0) begin
            h_sz = CMP_W'(1);
        end else if (h_raw > CMP_W'(MAX_DIM)) begin
            h_sz = CMP_W'(MAX_DIM);
        end else begin
            h_sz = h_raw;
        end
        if (w_raw == '0) begin
            w_sz = CMP_W'(1);
        end else if (w_raw > CMP_W'(MAX_DIM)) begin
            w_sz = CMP_W'(MAX_DIM);
        end else begin
            w_sz = w_raw;
        end
        row_inc = CMP_W'(r_row) + CMP_W'(1);
        col_inc = CMP_W'(r_col) + CMP_W'(1);
    end

    assign frame_start = (r_row == '0) && (r_col == '0);
    assign in_range    = ({1'b0, i_label} < (LABEL_W + 1)'(NUM_LABELS));

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_ovf   = r_ovf;
        kind    = K_READ_ABSENT;
        ent_ovf = r_ovf;
        case (i_command)
            CMD_PIXEL: begin
                kind  = in_range ? K_PIXEL : K_PIXEL_SKIP;
                n_ovf = (frame_start ? 1'b0 : r_ovf) | !in_range;
                if (col_inc >= w_sz) begin
                    n_col = '0;
                    if (row_inc >= h_sz) begin
                        n_row = '0;
                    end else begin
                        n_row = row_inc[DIM_W-1:0];
                    end
                end else begin
                    n_col = col_inc[DIM_W-1:0];
                end
            end
            CMD_READ: begin
                kind = in_range ? K_READ : K_READ_ABSENT;
            end
            default: begin
                kind = K_READ_ABSENT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_ovf <= 1'b0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
            r_ovf <= n_ovf;
        end
    end

    assign o_push  = i_accept;
    assign o_entry = {kind, frame_start && (i_command == CMD_PIXEL), ent_ovf,
                      i_label[LBL_W-1:0], r_row, r_col};

endmodule

[rtl/lbbt_queue.sv]
// short fifo between front end and back end
// depends on lbbt_pkg
module lbbt_queue
    import lbbt_pkg::*;
#(
    parameter int ENT_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [ENT_W-1:0] i_data,
    input  logic             i_pop,
    output logic [ENT_W-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [ENT_W-1:0]  r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/lbbt_back.sv]
// back end: box table read-modify-write, valid marks and read results
// depends on lbbt_pkg; drives the box ram
module lbbt_back
    import lbbt_pkg::*;
#(
    parameter int NUM_LABELS = 256,
    parameter int LBL_W      = 8,
    parameter int DIM_W      = 12,
    parameter int ENT_W      = 4 + LBL_W + 2 * DIM_W,
    parameter int BOX_W      = 4 * DIM_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [ENT_W-1:0]   i_q_data,
    output logic               o_q_pop,
    output logic               o_ram_we,
    output logic [LBL_W-1:0]   o_ram_waddr,
    output logic [BOX_W-1:0]   o_ram_wdata,
    output logic               o_ram_re,
    output logic [LBL_W-1:0]   o_ram_raddr,
    input  logic [BOX_W-1:0]   i_ram_rdata,
    output logic               o_result_valid,
    output logic               o_present,
    output logic [FIRST_W-1:0] o_row_first,
    output logic [END_W-1:0]   o_row_end,
    output logic [FIRST_W-1:0] o_col_first,
    output logic [END_W-1:0]   o_col_end,
    output logic               o_label_overflow
);

    t_back_state          r_state, n_state;
    logic [ENT_W-1:0]     r_ent;
    logic [NUM_LABELS-1:0] r_valid, n_valid;

    logic                 r_res_valid;
    logic                 r_present;
    logic [FIRST_W-1:0]   r_row_first, r_col_first;
    logic [END_W-1:0]     r_row_end, r_col_end;
    logic                 r_ovf_out;

    t_kind                e_kind;
    logic                 e_fs, e_ovf;
    logic [LBL_W-1:0]     e_lbl;
    logic [DIM_W-1:0]     e_row, e_col;
    logic [DIM_W-1:0]     b_row_lo, b_row_hi, b_col_lo, b_col_hi;
    logic [DIM_W-1:0]     w_row_lo, w_row_hi, w_col_lo, w_col_hi;
    logic                 hit;
    logic                 exec;

    assign e_kind = t_kind'(r_ent[ENT_W-1 -: 2]);
    assign e_fs   = r_ent[ENT_W-3];
    assign e_ovf  = r_ent[ENT_W-4];
    assign e_lbl  = r_ent[2*DIM_W +: LBL_W];
    assign e_row  = r_ent[DIM_W +: DIM_W];
    assign e_col  = r_ent[DIM_W-1:0];

    assign {b_row_lo, b_row_hi, b_col_lo, b_col_hi} = i_ram_rdata;

    assign exec = (r_state == ST_EXEC);
    assign hit  = r_valid[e_lbl] && !e_fs;

    always_comb begin
        w_row_lo = hit && (b_row_lo < e_row) ? b_row_lo : e_row;
        w_row_hi = hit && (b_row_hi > e_row) ? b_row_hi : e_row;
        w_col_lo = hit && (b_col_lo < e_col) ? b_col_lo : e_col;
        w_col_hi = hit && (b_col_hi > e_col) ? b_col_hi : e_col;
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (exec) begin
            if (e_fs) begin
                n_valid = '0;
            end
            if (e_kind == K_PIXEL) begin
                n_valid[e_lbl] = 1'b1;
            end
        end
    end

    assign o_ram_re    = o_q_pop;
    assign o_ram_raddr = i_q_data[2*DIM_W +: LBL_W];
    assign o_ram_we    = exec && (e_kind == K_PIXEL);
    assign o_ram_waddr = e_lbl;
    assign o_ram_wdata = {w_row_lo, w_row_hi, w_col_lo, w_col_hi};

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_data;
        end
        if (exec) begin
            r_ovf_out <= e_ovf;
            if ((e_kind == K_READ) && r_valid[e_lbl]) begin
                r_present   <= 1'b1;
                r_row_first <= FIRST_W'(b_row_lo);
                r_row_end   <= END_W'({1'b0, b_row_hi} + 1'b1);
                r_col_first <= FIRST_W'(b_col_lo);
                r_col_end   <= END_W'({1'b0, b_col_hi} + 1'b1);
            end else begin
                r_present   <= 1'b0;
                r_row_first <= '0;
                r_row_end   <= '0;
                r_col_first <= '0;
                r_col_end   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_res_valid <= exec && ((e_kind == K_READ) || (e_kind == K_READ_ABSENT));
        end
    end

    assign o_result_valid   = r_res_valid;
    assign o_present        = r_present;
    assign o_row_first      = r_row_first;
    assign o_row_end        = r_row_end;
    assign o_col_first      = r_col_first;
    assign o_col_end        = r_col_end;
    assign o_label_overflow = r_ovf_out;

endmodule

[sim/labeled_bounding_box_table_tb.sv]
// self-checking testbench for labeled_bounding_box_table: drives pixel and read
// transactions with random gaps and checks each box result against a predictor
// depends on lbbt_pkg and the labeled_bounding_box_table rtl
`timescale 1ns / 1ps

module labeled_bounding_box_table_tb;
    import lbbt_pkg::*;

    localparam int NUM_LABELS = 256;
    localparam int MAX_DIM    = 4096;
    localparam int PALETTE_N  = 6;
    localparam int N_PHASES   = 9;

    typedef struct packed {
        logic                 cmd;
        logic [LABEL_W-1:0]   label;
    } t_stim_item;

    typedef struct packed {
        logic                 present;
        logic [FIRST_W-1:0]   row_first;
        logic [END_W-1:0]     row_end;
        logic [FIRST_W-1:0]   col_first;
        logic [END_W-1:0]     col_end;
        logic                 overflow;
    } t_box_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_command = CMD_PIXEL;
    logic [LABEL_W-1:0]    i_label = '0;
    logic                  o_result_valid;
    logic                  o_present;
    logic [FIRST_W-1:0]    o_row_first;
    logic [END_W-1:0]      o_row_end;
    logic [FIRST_W-1:0]    o_col_first;
    logic [END_W-1:0]      o_col_end;
    logic                  o_label_overflow;

    // predictor state
    logic [FIRST_W-1:0] top_row [NUM_LABELS];
    logic [FIRST_W-1:0] bot_row [NUM_LABELS];
    logic [FIRST_W-1:0] left_col [NUM_LABELS];
    logic [FIRST_W-1:0] right_col [NUM_LABELS];
    bit                 seen [NUM_LABELS];
    logic [FIRST_W-1:0] cur_row = '0;
    logic [FIRST_W-1:0] cur_col = '0;
    bit                 ovf_seen = 1'b0;
    logic [CFG_W-1:0]   cfg_height = HEIGHT_RESET;
    logic [CFG_W-1:0]   cfg_width = WIDTH_RESET;

    t_stim_item label_stream [$];
    t_box_reply pending_boxes [$];
    int         palette [PALETTE_N];
    bit         took = 1'b0;
    int         drive_cycle = 0;
    int         n_fail = 0;
    int         n_items = 0;
    int         n_reads = 0;

    int ph_height [N_PHASES] = '{0, 4, 7, 16, 1, 6, 8191, 3, 1024};
    int ph_width [N_PHASES]  = '{0, 4, 5, 16, 9, 0, 2, 3, 1024};
    int ph_items [N_PHASES]  = '{60, 110, 110, 130, 90, 70, 110, 90, 100};

    labeled_bounding_box_table #(
        .NUM_LABELS (NUM_LABELS),
        .MAX_DIM    (MAX_DIM)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_label          (i_label),
        .o_result_valid   (o_result_valid),
        .o_present        (o_present),
        .o_row_first      (o_row_first),
        .o_row_end        (o_row_end),
        .o_col_first      (o_col_first),
        .o_col_end        (o_col_end),
        .o_label_overflow (o_label_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_size(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    task automatic apply_transaction(input logic cmd, input logic [LABEL_W-1:0] label);
        t_box_reply reply;
        if (cmd == CMD_PIXEL) begin
            if (cur_row == 0 && cur_col == 0) begin
                foreach (seen[k]) seen[k] = 1'b0;
                ovf_seen = 1'b0;
            end
            if (label >= NUM_LABELS) begin
                ovf_seen = 1'b1;
            end else if (!seen[label]) begin
                top_row[label]   = cur_row;
                bot_row[label]   = cur_row;
                left_col[label]  = cur_col;
                right_col[label] = cur_col;
                seen[label]      = 1'b1;
            end else begin
                if (cur_row < top_row[label]) top_row[label] = cur_row;
                if (cur_row > bot_row[label]) bot_row[label] = cur_row;
                if (cur_col < left_col[label]) left_col[label] = cur_col;
                if (cur_col > right_col[label]) right_col[label] = cur_col;
            end
            // raster advance, wrapping anything at or past the size in force
            if (int'(cur_col) + 1 >= eff_size(cfg_width)) begin
                cur_col = '0;
                if (int'(cur_row) + 1 >= eff_size(cfg_height)) cur_row = '0;
                else cur_row = cur_row + 1'b1;
            end else begin
                cur_col = cur_col + 1'b1;
            end
        end else begin
            reply = '0;
            if (label < NUM_LABELS && seen[label]) begin
                reply.present   = 1'b1;
                reply.row_first = top_row[label];
                reply.row_end   = {1'b0, bot_row[label]} + 1'b1;
                reply.col_first = left_col[label];
                reply.col_end   = {1'b0, right_col[label]} + 1'b1;
            end
            reply.overflow = ovf_seen;
            pending_boxes.push_back(reply);
        end
    endtask

    // driver: holds a transaction until accepted, with random idle gaps
    always @(negedge i_clk) begin : drive_proc
        t_stim_item nxt;
        bit         gap;
        drive_cycle++;
        gap = (drive_cycle < 800 || drive_cycle >= 1600) && ($urandom_range(99) < 9);
        if (i_rst_n && (!start || took)) begin
            if (label_stream.size() != 0 && !gap) begin
                nxt = label_stream.pop_front();
                start     <= 1'b1;
                i_command <= nxt.cmd;
                i_label   <= nxt.label;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: checks result strobes, then predicts the accepted transaction
    always @(posedge i_clk) begin : monitor_proc
        t_box_reply want;
        took <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_result_valid) begin
                n_reads++;
                if (pending_boxes.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) $display("unexpected box result at %0t", $realtime);
                end else begin
                    want = pending_boxes.pop_front();
                    if (o_present !== want.present || o_row_first !== want.row_first ||
                        o_row_end !== want.row_end || o_col_first !== want.col_first ||
                        o_col_end !== want.col_end || o_label_overflow !== want.overflow) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display({"box mismatch at %0t: expected ",
                                "p=%0d r=%0d..%0d c=%0d..%0d ovf=%0d"},
                                $realtime, want.present, want.row_first, want.row_end,
                                want.col_first, want.col_end, want.overflow);
                            $display("    got p=%0d r=%0d..%0d c=%0d..%0d ovf=%0d",
                                o_present, o_row_first, o_row_end, o_col_first, o_col_end,
                                o_label_overflow);
                        end
                    end
                end
            end
            if (start && !busy) begin
                n_items++;
                apply_transaction(i_command, i_label);
            end
        end
    end

    task automatic verify_reg(input logic idx, input logic [CFG_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {{(APB_DATA_W-CFG_W){1'b0}}, want}) begin
            n_fail++;
            if (n_fail <= 10) $display("register %0d readback: expected %0d, got %0d",
                idx, want, got);
        end
    endtask

    task automatic write_size(input logic idx, input int value);
        logic [APB_DATA_W-1:0] data;
        data = ($urandom() & 32'hFFFF_E000) | (value & 32'h1FFF);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IDX_HEIGHT) cfg_height = data[CFG_W-1:0];
        else cfg_width = data[CFG_W-1:0];
        verify_reg(idx, data[CFG_W-1:0]);
    endtask

    task automatic push_item(input logic cmd, input int label);
        t_stim_item it;
        it.cmd   = cmd;
        it.label = label[LABEL_W-1:0];
        label_stream.push_back(it);
    endtask

    function automatic int pick_label(int far_pct);
        int r;
        r = $urandom_range(99);
        if (r < far_pct) return $urandom_range(1023, NUM_LABELS);
        if (r < far_pct + 10) return $urandom_range(NUM_LABELS - 1, 0);
        return palette[$urandom_range(PALETTE_N - 1, 0)];
    endfunction

    task automatic new_palette();
        foreach (palette[k]) palette[k] = $urandom_range(NUM_LABELS - 1, 0);
    endtask

    // wait for the stream to drain and all box results to arrive, or a wait limit to run out
    task automatic settle();
        int waited;
        waited = 0;
        while (label_stream.size() != 0 || start) @(posedge i_clk);
        while (pending_boxes.size() != 0 && waited < 400) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (24) @(posedge i_clk);
    endtask

    task automatic random_burst(input int count, input int read_pct);
        new_palette();
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < read_pct) push_item(CMD_READ, pick_label(15));
            else push_item(CMD_PIXEL, pick_label(6));
        end
        settle();
    endtask

    // one whole frame from raster origin, then read back every palette label
    task automatic frame_sweep(input int height, input int width);
        write_size(REG_IDX_HEIGHT, 1);
        write_size(REG_IDX_WIDTH, 1);
        push_item(CMD_PIXEL, pick_label(0));
        settle();
        write_size(REG_IDX_HEIGHT, height);
        write_size(REG_IDX_WIDTH, width);
        new_palette();
        for (int n = 0; n < eff_size(height) * eff_size(width); n++) begin
            push_item(CMD_PIXEL, pick_label(2));
            if ($urandom_range(99) < 2) push_item(CMD_READ, pick_label(10));
        end
        foreach (palette[k]) push_item(CMD_READ, palette[k]);
        push_item(CMD_READ, 1023);
        settle();
    endtask

    initial begin : stimulus
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        verify_reg(REG_IDX_HEIGHT, HEIGHT_RESET);
        verify_reg(REG_IDX_WIDTH, WIDTH_RESET);

        // directed: 3 x 4 frame with extremes, absent and out-of-range labels
        write_size(REG_IDX_HEIGHT, 3);
        write_size(REG_IDX_WIDTH, 4);
        push_item(CMD_READ, 0);
        push_item(CMD_PIXEL, 0);
        push_item(CMD_PIXEL, 1023);
        push_item(CMD_PIXEL, 255);
        push_item(CMD_PIXEL, 0);
        push_item(CMD_READ, 0);
        push_item(CMD_READ, 1023);
        push_item(CMD_READ, 256);
        push_item(CMD_PIXEL, 256);
        push_item(CMD_PIXEL, 7);
        push_item(CMD_PIXEL, 255);
        push_item(CMD_PIXEL, 0);
        push_item(CMD_PIXEL, 7);
        push_item(CMD_PIXEL, 512);
        push_item(CMD_PIXEL, 255);
        push_item(CMD_PIXEL, 0);
        push_item(CMD_READ, 255);
        push_item(CMD_READ, 7);
        push_item(CMD_READ, 0);
        push_item(CMD_READ, 128);
        push_item(CMD_PIXEL, 5);
        push_item(CMD_READ, 0);
        push_item(CMD_READ, 5);
        push_item(CMD_READ, 1023);
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            write_size(REG_IDX_HEIGHT, ph_height[p]);
            write_size(REG_IDX_WIDTH, ph_width[p]);
            random_burst(ph_items[p], 25);
        end
        frame_sweep(1, 24);
        frame_sweep(24, 1);

        if (pending_boxes.size() != 0) begin
            $display("%0d box results never arrived", pending_boxes.size());
            n_fail += pending_boxes.size();
        end
        $display("run covered %0d transactions and %0d box results over %0d size settings",
            n_items, n_reads, N_PHASES + 3);
        $display("mismatches: %0d", n_fail);
        if (n_fail == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("run timed out");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
